[src/rocket_flight_stage_detector_assert.svh]
// Assertion macros used by the detector top level.
`ifndef ROCKET_FLIGHT_STAGE_DETECTOR_ASSERT_SVH
`define ROCKET_FLIGHT_STAGE_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define RFSD_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfsd same-cycle check failed");

`define RFSD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfsd next-cycle check failed");

`else

`define RFSD_ASSERT_IMPL(name, ante, cons)

`define RFSD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[src/rfsd_pkg.sv]
package rfsd_pkg;

	localparam int SAMPLE_W   = 21;
	localparam int REL_W      = 22;
	localparam int WINDOW     = 15;
	localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
	localparam int DIV_SHIFT  = 32;
	localparam int RECIP_W    = DIV_SHIFT;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	localparam int THR_W      = 17;
	localparam int HOLD_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int CAL_W = 6;
	localparam logic [CAL_W-1:0] CAL_START   = 6'd30;
	localparam logic [CAL_W-1:0] CAL_CAPTURE = 6'd1;
	localparam logic [CAL_W-1:0] CAL_DONE    = 6'd63;

	localparam int EV_W = 3;
	localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EV_W-1:0] EV_LIFTOFF = 3'd1;
	localparam logic [EV_W-1:0] EV_TARGET  = 3'd2;
	localparam logic [EV_W-1:0] EV_APOGEE  = 3'd3;
	localparam logic [EV_W-1:0] EV_REEF    = 3'd4;
	localparam logic [EV_W-1:0] EV_LANDED  = 3'd5;

	localparam int FLAG_W = 5;
	localparam logic [FLAG_W-1:0] F_LIFTOFF = 5'b00001;
	localparam logic [FLAG_W-1:0] F_TARGET  = 5'b00010;
	localparam logic [FLAG_W-1:0] F_APOGEE  = 5'b00100;
	localparam logic [FLAG_W-1:0] F_REEF    = 5'b01000;
	localparam logic [FLAG_W-1:0] F_LANDED  = 5'b10000;

	localparam int LED_W = 4;
	localparam logic [LED_W-1:0] LED_LIFTOFF = 4'h4;
	localparam logic [LED_W-1:0] LED_TARGET  = 4'h2;
	localparam logic [LED_W-1:0] LED_APOGEE  = 4'h1;
	localparam logic [LED_W-1:0] LED_REEF    = 4'h3;
	localparam logic [LED_W-1:0] LED_LANDED  = 4'h6;

	localparam logic [CFG_IDX_W-1:0] REG_LIFTOFF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_APOGEE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REEF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LANDED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd5;

	typedef struct packed {
		logic [THR_W-1:0]  liftoff;
		logic [THR_W-1:0]  target;
		logic [THR_W-1:0]  apogee_drop;
		logic [THR_W-1:0]  reef;
		logic [THR_W-1:0]  landed;
		logic [HOLD_W-1:0] hold;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		liftoff:     17'd300,
		target:      17'd500,
		apogee_drop: 17'd300,
		reef:        17'd200,
		landed:      17'd50,
		hold:        8'd10
	};

endpackage

[src/rfsd_cell.sv]
module rfsd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  logic [rfsd_pkg::SAMPLE_W-1:0] sample_in,
	output logic [rfsd_pkg::SAMPLE_W-1:0] sample_out
);

	logic [rfsd_pkg::SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= sample_in;
		end
	end

	assign sample_out = sample_q;

endmodule

[src/rfsd_window.sv]
module rfsd_window (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [rfsd_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [rfsd_pkg::SAMPLE_W-1:0] mean
);

	logic [rfsd_pkg::WINDOW:0][rfsd_pkg::SAMPLE_W-1:0] tap;

	logic                                 accept;
	logic                                 rdy2, rdy3;
	logic                                 v_s1, v_s2, v_s3;
	logic signed [rfsd_pkg::SUM_W-1:0]    sum_q;
	logic [rfsd_pkg::SUM_W-1:0]           mag;
	logic [rfsd_pkg::PROD_W-1:0]          prod_s2;
	logic                                 neg_s2;
	logic [rfsd_pkg::SAMPLE_W-1:0]        quot;
	logic signed [rfsd_pkg::SAMPLE_W-1:0] mean_s3;

	assign rdy3     = ~v_s3 | out_ready;
	assign rdy2     = ~v_s2 | rdy3;
	assign in_ready = ~v_s1 | rdy2;
	assign accept   = in_valid & in_ready;

	// shift line: cell 0 takes the new sample, the last cell holds the oldest
	assign tap[0] = sample;

	for (genvar i = 0; i < rfsd_pkg::WINDOW; i++) begin : g_cell
		rfsd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (accept),
			.sample_in  (tap[i]),
			.sample_out (tap[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			if (accept) begin
				sum_q <= sum_q + rfsd_pkg::SUM_W'(sample)
					- rfsd_pkg::SUM_W'($signed(tap[rfsd_pkg::WINDOW]));
			end
			v_s1 <= accept | (v_s1 & ~rdy2);
			v_s2 <= (v_s1 & rdy2) | (v_s2 & ~rdy3);
			v_s3 <= (v_s2 & rdy3) | (v_s3 & ~out_ready);
		end
	end

	// divide by the window as magnitude times reciprocal, sign restored after
	assign mag  = sum_q[rfsd_pkg::SUM_W-1] ? rfsd_pkg::SUM_W'(-sum_q)
		: rfsd_pkg::SUM_W'(sum_q);
	assign quot = prod_s2[rfsd_pkg::DIV_SHIFT +: rfsd_pkg::SAMPLE_W];

	always_ff @(posedge clk) begin
		if (v_s1 & rdy2) begin
			neg_s2  <= sum_q[rfsd_pkg::SUM_W-1];
			prod_s2 <= rfsd_pkg::PROD_W'(mag) * rfsd_pkg::PROD_W'(rfsd_pkg::RECIP);
		end
		if (v_s2 & rdy3) begin
			mean_s3 <= neg_s2 ? -quot : quot;
		end
	end

	assign out_valid = v_s3;
	assign mean      = mean_s3;

endmodule

[src/rfsd_flight.sv]
module rfsd_flight (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rfsd_pkg::cfg_t                       cfg,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [rfsd_pkg::SAMPLE_W-1:0] mean,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [rfsd_pkg::SAMPLE_W-1:0] mean_altitude_cm,
	output logic signed [rfsd_pkg::REL_W-1:0]    relative_height_cm,
	output logic [rfsd_pkg::EV_W-1:0]            event_code,
	output logic [rfsd_pkg::FLAG_W-1:0]          stage_flags,
	output logic [rfsd_pkg::LED_W-1:0]           led_mask,
	output logic [rfsd_pkg::EV_W-1:0]            tone_select,
	output logic                                 calibrated
);

	function automatic logic signed [rfsd_pkg::REL_W:0] thr_ext(
		input logic [rfsd_pkg::THR_W-1:0] t
	);
		return {{(rfsd_pkg::REL_W + 1 - rfsd_pkg::THR_W){1'b0}}, t};
	endfunction

	logic rdy5, acc4, mov45;

	logic [rfsd_pkg::CAL_W-1:0]           cal_q, cal_n;
	logic signed [rfsd_pkg::SAMPLE_W-1:0] base_q, base_n;
	logic signed [rfsd_pkg::REL_W-1:0]    rel_n;

	logic                                 v_s4, done_s4;
	logic signed [rfsd_pkg::SAMPLE_W-1:0] mean_s4;
	logic signed [rfsd_pkg::REL_W-1:0]    rel_s4;

	logic                                 v_s5, done_s5;
	logic signed [rfsd_pkg::SAMPLE_W-1:0] mean_s5;
	logic signed [rfsd_pkg::REL_W-1:0]    rel_s5;
	logic [rfsd_pkg::EV_W-1:0]            ev_s5;

	logic [rfsd_pkg::FLAG_W-1:0]       flags_q, flags_n;
	logic signed [rfsd_pkg::REL_W-1:0] peak_q, peak_n;
	logic [rfsd_pkg::LED_W-1:0]        led_q, led_n;
	logic [rfsd_pkg::EV_W-1:0]         tone_q, tone_n;
	logic [rfsd_pkg::HOLD_W-1:0]       hold_q, hold_n;
	logic [rfsd_pkg::EV_W-1:0]         ev_n;

	logic                              fire;
	logic [rfsd_pkg::FLAG_W-1:0]       fire_flag;
	logic [rfsd_pkg::LED_W-1:0]        fire_led;
	logic signed [rfsd_pkg::REL_W:0]   rel_x, peak_x, drop_x;

	assign rdy5     = ~v_s5 | out_ready;
	assign in_ready = ~v_s4 | rdy5;
	assign acc4     = in_valid & in_ready;
	assign mov45    = v_s4 & rdy5;

	// calibration and baseline
	assign cal_n  = (cal_q != rfsd_pkg::CAL_DONE) ? cal_q - rfsd_pkg::CAL_W'(1) : cal_q;
	assign base_n = (cal_n == rfsd_pkg::CAL_CAPTURE) ? mean : base_q;
	assign rel_n  = rfsd_pkg::REL_W'(mean) - rfsd_pkg::REL_W'(base_n);

	// stage rules
	assign rel_x  = {rel_s4[rfsd_pkg::REL_W-1], rel_s4};
	assign peak_x = {peak_q[rfsd_pkg::REL_W-1], peak_q};
	// drop from peak; a new peak gives a drop below zero, which never exceeds the limit
	assign drop_x = peak_x - rel_x;

	always_comb begin
		ev_n      = rfsd_pkg::EV_NONE;
		fire      = 1'b0;
		fire_flag = '0;
		fire_led  = '0;
		peak_n    = peak_q;
		flags_n   = flags_q;
		led_n     = led_q;
		tone_n    = tone_q;
		hold_n    = hold_q;

		if (done_s4) begin
			if ((flags_q & rfsd_pkg::F_LIFTOFF) == '0) begin
				if (rel_x > thr_ext(cfg.liftoff)) begin
					fire      = 1'b1;
					ev_n      = rfsd_pkg::EV_LIFTOFF;
					fire_flag = rfsd_pkg::F_LIFTOFF;
					fire_led  = rfsd_pkg::LED_LIFTOFF;
					peak_n    = rel_s4;
				end
			end else if ((flags_q & rfsd_pkg::F_LANDED) == '0) begin
				if (rel_x > peak_x) begin
					peak_n = rel_s4;
				end
				if (((flags_q & rfsd_pkg::F_TARGET) == '0) && (rel_x > thr_ext(cfg.target))) begin
					fire      = 1'b1;
					ev_n      = rfsd_pkg::EV_TARGET;
					fire_flag = rfsd_pkg::F_TARGET;
					fire_led  = rfsd_pkg::LED_TARGET;
				end else if (((flags_q & rfsd_pkg::F_APOGEE) == '0)
					&& (drop_x > thr_ext(cfg.apogee_drop))) begin
					fire      = 1'b1;
					ev_n      = rfsd_pkg::EV_APOGEE;
					fire_flag = rfsd_pkg::F_APOGEE;
					fire_led  = rfsd_pkg::LED_APOGEE;
				end else if (((flags_q & rfsd_pkg::F_REEF) == '0)
					&& ((flags_q & rfsd_pkg::F_APOGEE) != '0)
					&& (rel_x < thr_ext(cfg.reef))) begin
					fire      = 1'b1;
					ev_n      = rfsd_pkg::EV_REEF;
					fire_flag = rfsd_pkg::F_REEF;
					fire_led  = rfsd_pkg::LED_REEF;
				end else if (rel_x < thr_ext(cfg.landed)) begin
					fire      = 1'b1;
					ev_n      = rfsd_pkg::EV_LANDED;
					fire_flag = rfsd_pkg::F_LANDED;
					fire_led  = rfsd_pkg::LED_LANDED;
				end
			end
		end

		if (fire) begin
			flags_n = flags_q | fire_flag;
			led_n   = led_q | fire_led;
			tone_n  = ev_n;
			hold_n  = cfg.hold;
		end

		if (hold_n != '0) begin
			hold_n = hold_n - rfsd_pkg::HOLD_W'(1);
			if (hold_n == '0) begin
				led_n  = '0;
				tone_n = rfsd_pkg::EV_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q   <= rfsd_pkg::CAL_START;
			base_q  <= '0;
			peak_q  <= '0;
			flags_q <= '0;
			led_q   <= '0;
			tone_q  <= rfsd_pkg::EV_NONE;
			hold_q  <= '0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
		end else begin
			if (acc4) begin
				cal_q  <= cal_n;
				base_q <= base_n;
			end
			if (mov45) begin
				peak_q  <= peak_n;
				flags_q <= flags_n;
				led_q   <= led_n;
				tone_q  <= tone_n;
				hold_q  <= hold_n;
			end
			v_s4 <= acc4 | (v_s4 & ~rdy5);
			v_s5 <= mov45 | (v_s5 & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (acc4) begin
			mean_s4 <= mean;
			rel_s4  <= rel_n;
			done_s4 <= (cal_n == rfsd_pkg::CAL_DONE);
		end
		if (mov45) begin
			mean_s5 <= mean_s4;
			rel_s5  <= rel_s4;
			ev_s5   <= ev_n;
			done_s5 <= done_s4;
		end
	end

	assign out_valid          = v_s5;
	assign mean_altitude_cm   = mean_s5;
	assign relative_height_cm = rel_s5;
	assign event_code         = ev_s5;
	assign calibrated         = done_s5;
	assign stage_flags        = flags_q;
	assign led_mask           = led_q;
	assign tone_select        = tone_q;

endmodule

[src/rocket_flight_stage_detector.sv]
// A result passes the window sum, product and mean registers, then the flight
// rule and output registers. Throughput: one sample per cycle unless result_ready
// stalls; the 15-cell shift line and running sum take each accepted sample.
// Reset (arst_n low, asynchronous): window cells, sum, calibration, flags,
// indicators and pipeline valids are reset at once; no sweep follows reset.
`include "rocket_flight_stage_detector_assert.svh"

module rocket_flight_stage_detector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [rfsd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rfsd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  logic signed [rfsd_pkg::SAMPLE_W-1:0]   altitude_cm,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic signed [rfsd_pkg::SAMPLE_W-1:0]   mean_altitude_cm,
	output logic signed [rfsd_pkg::REL_W-1:0]      relative_height_cm,
	output logic [rfsd_pkg::EV_W-1:0]              event_code,
	output logic [rfsd_pkg::FLAG_W-1:0]            stage_flags,
	output logic [rfsd_pkg::LED_W-1:0]             led_mask,
	output logic [rfsd_pkg::EV_W-1:0]              tone_select,
	output logic                                   calibrated
);

	rfsd_pkg::cfg_t cfg_q;

	logic                                 mean_valid, mean_ready;
	logic signed [rfsd_pkg::SAMPLE_W-1:0] mean;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rfsd_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rfsd_pkg::REG_LIFTOFF: cfg_q.liftoff     <= cfg_data[rfsd_pkg::THR_W-1:0];
				rfsd_pkg::REG_TARGET:  cfg_q.target      <= cfg_data[rfsd_pkg::THR_W-1:0];
				rfsd_pkg::REG_APOGEE:  cfg_q.apogee_drop <= cfg_data[rfsd_pkg::THR_W-1:0];
				rfsd_pkg::REG_REEF:    cfg_q.reef        <= cfg_data[rfsd_pkg::THR_W-1:0];
				rfsd_pkg::REG_LANDED:  cfg_q.landed      <= cfg_data[rfsd_pkg::THR_W-1:0];
				rfsd_pkg::REG_HOLD:    cfg_q.hold        <= cfg_data[rfsd_pkg::HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rfsd_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_ready  (sample_ready),
		.sample    (altitude_cm),
		.out_valid (mean_valid),
		.out_ready (mean_ready),
		.mean      (mean)
	);

	rfsd_flight u_flight (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.in_valid           (mean_valid),
		.in_ready           (mean_ready),
		.mean               (mean),
		.out_valid          (result_valid),
		.out_ready          (result_ready),
		.mean_altitude_cm   (mean_altitude_cm),
		.relative_height_cm (relative_height_cm),
		.event_code         (event_code),
		.stage_flags        (stage_flags),
		.led_mask           (led_mask),
		.tone_select        (tone_select),
		.calibrated         (calibrated)
	);

	`RFSD_ASSERT_IMPL(a_event_sets_flag, result_valid && (event_code != rfsd_pkg::EV_NONE), stage_flags != '0)
	`RFSD_ASSERT_IMPL(a_quiet_before_cal, result_valid && !calibrated, (event_code == rfsd_pkg::EV_NONE) && (stage_flags == '0))
	`RFSD_ASSERT_IMPL(a_reef_needs_apogee, (stage_flags & rfsd_pkg::F_REEF) != '0, (stage_flags & rfsd_pkg::F_APOGEE) != '0)
	`RFSD_ASSERT_NEXT(a_flags_sticky, 1'b1, (stage_flags & $past(stage_flags)) == $past(stage_flags))

endmodule

[sim/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GROUND_CM   = 12000;
	localparam int ITEMS_TOTAL = 1950;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [rfsd_pkg::SAMPLE_W-1:0] GROUND_ALT =
		rfsd_pkg::SAMPLE_W'(GROUND_CM);

	typedef struct packed {
		logic [rfsd_pkg::SAMPLE_W-1:0] mean;
		logic [rfsd_pkg::REL_W-1:0]    rel;
		logic [rfsd_pkg::EV_W-1:0]     ev;
		logic [rfsd_pkg::FLAG_W-1:0]   flags;
		logic [rfsd_pkg::LED_W-1:0]    leds;
		logic [rfsd_pkg::EV_W-1:0]     tone;
		logic                          cal;
	} flight_report_t;

	typedef struct {
		logic signed [rfsd_pkg::SAMPLE_W-1:0] alt;
		bit                                   typed;
		flight_report_t                       want;
	} opening_row_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_wr_en = 1'b0;
	logic [rfsd_pkg::CFG_IDX_W-1:0]       cfg_index = rfsd_pkg::REG_LIFTOFF;
	logic [rfsd_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
	logic                                 sample_valid = 1'b0;
	logic                                 sample_ready;
	logic signed [rfsd_pkg::SAMPLE_W-1:0] altitude_cm = '0;
	logic                                 result_valid;
	logic                                 result_ready = 1'b0;
	logic signed [rfsd_pkg::SAMPLE_W-1:0] mean_altitude_cm;
	logic signed [rfsd_pkg::REL_W-1:0]    relative_height_cm;
	logic [rfsd_pkg::EV_W-1:0]            event_code;
	logic [rfsd_pkg::FLAG_W-1:0]          stage_flags;
	logic [rfsd_pkg::LED_W-1:0]           led_mask;
	logic [rfsd_pkg::EV_W-1:0]            tone_select;
	logic                                 calibrated;

	rocket_flight_stage_detector dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.sample_valid       (sample_valid),
		.sample_ready       (sample_ready),
		.altitude_cm        (altitude_cm),
		.result_valid       (result_valid),
		.result_ready       (result_ready),
		.mean_altitude_cm   (mean_altitude_cm),
		.relative_height_cm (relative_height_cm),
		.event_code         (event_code),
		.stage_flags        (stage_flags),
		.led_mask           (led_mask),
		.tone_select        (tone_select),
		.calibrated         (calibrated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// flight tracker state
	int                             ring_cells [rfsd_pkg::WINDOW] = '{default: 0};
	int                             window_total = 0;
	int                             ring_pos = 0;
	logic [rfsd_pkg::CAL_W-1:0]     cal_count = rfsd_pkg::CAL_START;
	int                             baseline = 0;
	int                             peak = 0;
	logic [rfsd_pkg::FLAG_W-1:0]    stage_reached = '0;
	logic [rfsd_pkg::LED_W-1:0]     lit_leds = '0;
	logic [rfsd_pkg::EV_W-1:0]      tone_now = rfsd_pkg::EV_NONE;
	logic [rfsd_pkg::HOLD_W-1:0]    hold_left = '0;
	rfsd_pkg::cfg_t                 cfg_live = rfsd_pkg::CFG_RESET;

	flight_report_t pending_reports [$];
	bit             steady = 1'b0;
	int             samples_sent = 0;
	int             reports_seen = 0;
	int             mismatch_count = 0;
	int             cycle_count = 0;
	int             event_tally [6] = '{default: 0};

	opening_row_t opening_rows [25] = '{
		'{21'sd0, 1'b1,
			'{21'sd0, 22'sd0, rfsd_pkg::EV_NONE, 5'd0, 4'd0, rfsd_pkg::EV_NONE, 1'b0}},
		'{21'sd1048575, 1'b1,
			'{21'sd69905, 22'sd69905, rfsd_pkg::EV_NONE, 5'd0, 4'd0, rfsd_pkg::EV_NONE,
			1'b0}},
		'{-21'sd1048576, 1'b1,
			'{21'sd0, 22'sd0, rfsd_pkg::EV_NONE, 5'd0, 4'd0, rfsd_pkg::EV_NONE, 1'b0}},
		'{-21'sd1048576, 1'b1,
			'{-21'sd69905, -22'sd69905, rfsd_pkg::EV_NONE, 5'd0, 4'd0, rfsd_pkg::EV_NONE,
			1'b0}},
		'{-21'sd1, 1'b0, '0},
		'{21'sd1, 1'b0, '0},
		'{21'sd1048575, 1'b0, '0},
		'{21'sd1048575, 1'b0, '0},
		'{21'h0AAAAA, 1'b0, '0},
		'{21'h155555, 1'b0, '0},
		'{21'sd524288, 1'b0, '0},
		'{-21'sd524288, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0},
		'{GROUND_ALT, 1'b0, '0}
	};

	function automatic void raise_event(output logic [rfsd_pkg::EV_W-1:0] ev,
			input logic [rfsd_pkg::EV_W-1:0] code, input logic [rfsd_pkg::FLAG_W-1:0] flag,
			input logic [rfsd_pkg::LED_W-1:0] leds);
		ev = code;
		stage_reached |= flag;
		lit_leds |= leds;
		tone_now = code;
		hold_left = cfg_live.hold;
	endfunction

	function automatic flight_report_t track_flight(
			input logic signed [rfsd_pkg::SAMPLE_W-1:0] alt);
		flight_report_t r;
		int mean, rel;
		int lift_thr, tgt_thr, drop_thr, reef_thr, land_thr;
		logic [rfsd_pkg::EV_W-1:0] ev;
		lift_thr = int'(cfg_live.liftoff);
		tgt_thr  = int'(cfg_live.target);
		drop_thr = int'(cfg_live.apogee_drop);
		reef_thr = int'(cfg_live.reef);
		land_thr = int'(cfg_live.landed);
		window_total = window_total - ring_cells[ring_pos] + int'(alt);
		ring_cells[ring_pos] = int'(alt);
		ring_pos = (ring_pos + 1) % rfsd_pkg::WINDOW;
		mean = window_total / rfsd_pkg::WINDOW;
		if (cal_count != rfsd_pkg::CAL_DONE)
			cal_count = cal_count - 6'd1;
		if (cal_count == rfsd_pkg::CAL_CAPTURE)
			baseline = mean;
		rel = mean - baseline;
		ev = rfsd_pkg::EV_NONE;
		if (cal_count == rfsd_pkg::CAL_DONE) begin
			if ((stage_reached & rfsd_pkg::F_LIFTOFF) == '0) begin
				if (rel > lift_thr) begin
					raise_event(ev, rfsd_pkg::EV_LIFTOFF, rfsd_pkg::F_LIFTOFF,
						rfsd_pkg::LED_LIFTOFF);
					peak = rel;
				end
			end else if ((stage_reached & rfsd_pkg::F_LANDED) == '0) begin
				if (rel > peak)
					peak = rel;
				if ((stage_reached & rfsd_pkg::F_TARGET) == '0 && rel > tgt_thr)
					raise_event(ev, rfsd_pkg::EV_TARGET, rfsd_pkg::F_TARGET,
						rfsd_pkg::LED_TARGET);
				else if ((stage_reached & rfsd_pkg::F_APOGEE) == '0 && peak - rel > drop_thr)
					raise_event(ev, rfsd_pkg::EV_APOGEE, rfsd_pkg::F_APOGEE,
						rfsd_pkg::LED_APOGEE);
				else if ((stage_reached & rfsd_pkg::F_REEF) == '0
						&& (stage_reached & rfsd_pkg::F_APOGEE) != '0
						&& rel < reef_thr)
					raise_event(ev, rfsd_pkg::EV_REEF, rfsd_pkg::F_REEF, rfsd_pkg::LED_REEF);
				else if (rel < land_thr)
					raise_event(ev, rfsd_pkg::EV_LANDED, rfsd_pkg::F_LANDED,
						rfsd_pkg::LED_LANDED);
			end
		end
		if (hold_left != '0) begin
			hold_left = hold_left - 8'd1;
			if (hold_left == '0) begin
				lit_leds = '0;
				tone_now = rfsd_pkg::EV_NONE;
			end
		end
		r.mean  = mean[rfsd_pkg::SAMPLE_W-1:0];
		r.rel   = rel[rfsd_pkg::REL_W-1:0];
		r.ev    = ev;
		r.flags = stage_reached;
		r.leds  = lit_leds;
		r.tone  = tone_now;
		r.cal   = (cal_count == rfsd_pkg::CAL_DONE);
		return r;
	endfunction

	function automatic logic signed [rfsd_pkg::SAMPLE_W-1:0] jitter_around(int center,
			int spread);
		int v;
		v = center + int'($urandom_range(2 * spread)) - spread;
		if (v > 1048575)
			v = 1048575;
		if (v < -1048576)
			v = -1048576;
		return v[rfsd_pkg::SAMPLE_W-1:0];
	endfunction

	task automatic log_mismatch(string msg);
		$display("[%0t] MISMATCH report %0d: %s", $realtime, reports_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string field, logic signed [31:0] got,
			logic signed [31:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0d want %0d", field, got, want));
	endtask

	task automatic push_sample(input logic signed [rfsd_pkg::SAMPLE_W-1:0] alt,
			input bit typed = 1'b0, input flight_report_t typed_want = '0);
		flight_report_t predicted;
		while (!steady && $urandom_range(99) < 18) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		altitude_cm <= alt;
		do @(posedge clk); while (!sample_ready);
		predicted = track_flight(alt);
		pending_reports.push_back(typed ? typed_want : predicted);
		samples_sent++;
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rfsd_pkg::CFG_IDX_W-1:0] idx,
			input logic [rfsd_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_config(input rfsd_pkg::cfg_t c);
		settle();
		write_reg(rfsd_pkg::REG_LIFTOFF, c.liftoff);
		write_reg(rfsd_pkg::REG_TARGET, c.target);
		write_reg(rfsd_pkg::REG_APOGEE, c.apogee_drop);
		write_reg(rfsd_pkg::REG_REEF, c.reef);
		write_reg(rfsd_pkg::REG_LANDED, c.landed);
		// upper data bits are don't-care for the hold register
		write_reg(rfsd_pkg::REG_HOLD, {9'($urandom), c.hold});
		cfg_wr_en <= 1'b0;
		cfg_live = c;
	endtask

	always @(posedge clk) begin
		flight_report_t got_report, want_report;
		result_ready <= steady || ($urandom_range(99) >= 18);
		if (result_valid && result_ready) begin
			got_report = '{mean_altitude_cm, relative_height_cm, event_code, stage_flags,
				led_mask, tone_select, calibrated};
			reports_seen++;
			if (event_code <= rfsd_pkg::EV_LANDED)
				event_tally[event_code]++;
			if (pending_reports.size() == 0) begin
				log_mismatch("transfer with no sample pending");
			end else begin
				want_report = pending_reports.pop_front();
				check_field("mean_altitude_cm", 32'($signed(got_report.mean)),
					32'($signed(want_report.mean)));
				check_field("relative_height_cm", 32'($signed(got_report.rel)),
					32'($signed(want_report.rel)));
				check_field("event_code", 32'(got_report.ev), 32'(want_report.ev));
				check_field("stage_flags", 32'(got_report.flags), 32'(want_report.flags));
				check_field("led_mask", 32'(got_report.leds), 32'(want_report.leds));
				check_field("tone_select", 32'(got_report.tone), 32'(want_report.tone));
				check_field("calibrated", 32'(got_report.cal), 32'(want_report.cal));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		rfsd_pkg::cfg_t c;
		int alt_now, climb_rate, fall_rate, seg_items;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i])
			push_sample(opening_rows[i].alt, opening_rows[i].typed, opening_rows[i].want);

		// on the pad: liftoff out of reach, baseline settles on calm samples
		c = '{17'h1FFFF, 17'd100000, 17'd100000, 17'd0, 17'd0, 8'd255};
		load_config(c);
		repeat (20) push_sample(jitter_around(GROUND_CM, 200));
		repeat (260) begin
			if ($urandom_range(99) < 4)
				push_sample(jitter_around(-524288, 524288));
			else
				push_sample(jitter_around(GROUND_CM, 60000));
		end
		repeat (20) push_sample(jitter_around(GROUND_CM, 200));

		// boost with zero hold: indicators latch
		c = rfsd_pkg::CFG_RESET;
		c.liftoff = 17'(1000 + $urandom_range(3000));
		c.target = 17'(6000 + $urandom_range(100000));
		c.apogee_drop = 17'd100000;
		c.reef = '0;
		c.landed = '0;
		c.hold = '0;
		load_config(c);
		repeat (30) push_sample(jitter_around(GROUND_CM, 300));
		alt_now = GROUND_CM;
		climb_rate = $urandom_range(700, 150);
		repeat ($urandom_range(140, 60)) begin
			alt_now += climb_rate;
			push_sample(jitter_around(alt_now, 150));
		end

		// coast and first descent with a one-tick hold
		c.hold = 8'd1;
		c.apogee_drop = 17'($urandom_range(8000, 1500));
		load_config(c);
		repeat ($urandom_range(40, 10)) push_sample(jitter_around(alt_now, 300));
		fall_rate = $urandom_range(900, 200);
		repeat ($urandom_range(60, 30)) begin
			alt_now -= fall_rate;
			if (alt_now < GROUND_CM - 2000)
				alt_now = GROUND_CM - 2000;
			push_sample(jitter_around(alt_now, 200));
		end

		// recovery: reefing and touchdown
		c.hold = 8'($urandom_range(40, 2));
		c.reef = 17'($urandom_range(30000));
		c.landed = 17'($urandom_range(3000));
		load_config(c);
		while (alt_now > GROUND_CM - 2000) begin
			alt_now -= fall_rate;
			push_sample(jitter_around(alt_now, 200));
		end
		repeat (60) push_sample(jitter_around(GROUND_CM - 2000, 300));

		// after touchdown: full-range samples under extreme and then random settings
		seg_items = (ITEMS_TOTAL - samples_sent) / 3;
		c = '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 8'd1};
		load_config(c);
		steady = 1'b1;
		repeat (seg_items) push_sample(rfsd_pkg::SAMPLE_W'($urandom));
		steady = 1'b0;
		c = '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 8'd255};
		load_config(c);
		repeat (seg_items) push_sample(rfsd_pkg::SAMPLE_W'($urandom));
		c = '{17'($urandom_range(131071)), 17'($urandom_range(131071)),
			17'($urandom_range(131071)), 17'($urandom_range(131071)),
			17'($urandom_range(131071)), 8'($urandom_range(255))};
		load_config(c);
		repeat (seg_items) push_sample(rfsd_pkg::SAMPLE_W'($urandom));

		settle();
		$display("Ran %0d altitude samples through one calibrated flight, %0d reports checked.",
			samples_sent, reports_seen);
		$display("Events liftoff/target/apogee/reef/landed: %0d/%0d/%0d/%0d/%0d, stages %b.",
			event_tally[rfsd_pkg::EV_LIFTOFF], event_tally[rfsd_pkg::EV_TARGET],
			event_tally[rfsd_pkg::EV_APOGEE], event_tally[rfsd_pkg::EV_REEF],
			event_tally[rfsd_pkg::EV_LANDED], stage_reached);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[rocket_flight_stage_detector.f]
+incdir+src
src/rfsd_pkg.sv
src/rfsd_cell.sv
src/rfsd_window.sv
src/rfsd_flight.sv
src/rocket_flight_stage_detector.sv
sim/testbench.sv
